### hw/rtl/hba_pkg.sv
package hba_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 48;
   localparam int GRAN_BYTES   = 8;
   localparam int GRANULES     = HEAP_BYTES / GRAN_BYTES;
   localparam int HDR_GRAN     = (HEADER_BYTES + GRAN_BYTES - 1) / GRAN_BYTES;
   localparam int HDR_SPAN     = HDR_GRAN * GRAN_BYTES;
   localparam int IDX_W        = $clog2(GRANULES);
   localparam int LNK_W        = IDX_W + 1;
   localparam int SIZE_W       = 16;

   localparam logic [LNK_W-1:0]  NIL       = LNK_W'(GRANULES);
   localparam logic [SIZE_W-1:0] HEAP_INIT = SIZE_W'(GRANULES * GRAN_BYTES - HDR_SPAN);

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_OOM    = 2'd1;
   localparam logic [1:0] ST_BADPTR = 2'd2;
   localparam logic [1:0] ST_DOUBLE = 2'd3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // link field touched by one patch step
   localparam logic [1:0] PK_FN   = 2'd0;
   localparam logic [1:0] PK_FP   = 2'd1;
   localparam logic [1:0] PK_PP   = 2'd2;
   localparam logic [1:0] PK_HEAD = 2'd3;

   typedef struct packed {
      logic             req_type;
      logic [15:0]      req_size;
      logic [15:0]      req_addr;
   } req_item_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [15:0]      block_addr;
      logic [15:0]      block_size;
   } rsp_item_type;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              used;
      logic [LNK_W-1:0]  pn;
      logic [LNK_W-1:0]  pp;
      logic [LNK_W-1:0]  fn;
      logic [LNK_W-1:0]  fp;
   } hdr_type;

   typedef struct packed {
      logic              en;
      logic [1:0]        kind;
      logic [IDX_W-1:0]  addr;
      logic [LNK_W-1:0]  val;
   } patch_type;

endpackage

### hw/rtl/hba_ram.sv
module hba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/heap_block_allocator.sv
// Allocate: walks the free list, one header per cycle through the single header memory port,
//   takes or splits the chosen block, then applies up to 3 link read-modify-writes;
//   an empty free list goes straight to the result strobe.
// A free checks the header, then merges and pushes; a double free ends after the header check.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: synchronous; after reset the block writes the whole-heap header, then goes idle.
// The result is shown for one cycle on rsp_valid; the receiver cannot stall.
module heap_block_allocator
   import hba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_data
);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_TAKE  = 4'd3;
   localparam logic [3:0] S_TSPL  = 4'd4;
   localparam logic [3:0] S_PQ    = 4'd5;
   localparam logic [3:0] S_PM    = 4'd6;
   localparam logic [3:0] S_FG    = 4'd7;
   localparam logic [3:0] S_FN    = 4'd8;
   localparam logic [3:0] S_FP0   = 4'd9;
   localparam logic [3:0] S_FP    = 4'd10;
   localparam logic [3:0] S_FPUSH = 4'd11;
   localparam logic [3:0] S_RESP  = 4'd12;

   logic [3:0]       state_ff, state_in, ret_ff, ret_in;
   logic [16:0]      sz_ff, sz_in;
   logic [IDX_W-1:0] cur_ff, cur_in, g_ff, g_in;
   logic [LNK_W-1:0] t_ff, t_in, head_ff, head_in;
   hdr_type          t_rec_ff, t_rec_in, g_rec_ff, g_rec_in;
   logic             strat_ff, strat_in;
   logic [1:0]       st_ff, st_in;
   logic [15:0]      baddr_ff, baddr_in, bsize_ff, bsize_in;
   patch_type        pq_ff [4];
   patch_type        pq_in [4];
   logic [1:0]       pidx_ff, pidx_in;

   logic             ram_re, ram_we;
   logic [IDX_W-1:0] ram_ra, ram_wa;
   hdr_type          ram_rd, ram_wd;

   hba_ram #(.WIDTH($bits(hdr_type)), .DEPTH(GRANULES)) u_ram (
      .clock   (clock),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd)
   );

   function automatic hdr_type apply_patch(hdr_type h, patch_type p);
      hdr_type r;
      r = h;
      case (p.kind)
         PK_FN:   r.fn = p.val;
         PK_FP:   r.fp = p.val;
         PK_PP:   r.pp = p.val;
         default: r = h;
      endcase
      return r;
   endfunction

   // datapath helpers
   logic             fit, take_new;
   logic [LNK_W-1:0] nxt;
   logic             split;
   logic [14:0]      nb_wide;
   logic [IDX_W-1:0] nb;
   logic [16:0]      addr_off;
   logic             bad_ptr;
   patch_type        pe;

   assign fit      = {1'b0, ram_rd.size} >= sz_ff;
   assign take_new = fit && (!strat_ff || t_ff == NIL || ram_rd.size < t_rec_ff.size);
   assign nxt      = ram_rd.fn;
   assign nb_wide  = 15'(t_ff) + 15'(HDR_GRAN) + 15'(sz_ff[16:3]);
   assign nb       = nb_wide[IDX_W-1:0];
   assign split    = ({2'b0, t_rec_ff.size} >= 18'(sz_ff) + 18'(HDR_SPAN))
                     && (nb_wide < 15'(GRANULES));
   assign addr_off = 17'(req_item.req_addr) - 17'(HDR_SPAN);
   assign bad_ptr  = (req_item.req_addr < 16'(HDR_SPAN))
                     || (17'(req_item.req_addr) >= 17'(GRANULES * GRAN_BYTES))
                     || (addr_off[2:0] != 3'd0);
   assign pe       = pq_ff[pidx_ff];

   // sequencer
   always_comb begin
      hdr_type h;
      state_in = state_ff;
      ret_in   = ret_ff;
      sz_in    = sz_ff;
      cur_in   = cur_ff;
      g_in     = g_ff;
      t_in     = t_ff;
      head_in  = head_ff;
      t_rec_in = t_rec_ff;
      g_rec_in = g_rec_ff;
      strat_in = strat_ff;
      st_in    = st_ff;
      baddr_in = baddr_ff;
      bsize_in = bsize_ff;
      pidx_in  = pidx_ff;
      for (int i = 0; i < 4; i++) pq_in[i] = pq_ff[i];
      ram_re = 1'b0;
      ram_ra = '0;
      ram_we = 1'b0;
      ram_wa = '0;
      ram_wd = '0;
      h      = '0;

      if (csr_valid) strat_in = csr_data;

      unique case (state_ff)
         S_INIT: begin
            ram_we   = 1'b1;
            ram_wa   = '0;
            ram_wd   = '{size: HEAP_INIT, used: 1'b0, pn: NIL, pp: NIL, fn: NIL, fp: NIL};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               st_in    = ST_OK;
               baddr_in = '0;
               bsize_in = '0;
               pidx_in  = '0;
               for (int i = 0; i < 4; i++) pq_in[i] = '0;
               if (req_item.req_type == REQ_ALLOC) begin
                  sz_in = (17'(req_item.req_size) + 17'd7) & ~17'd7;
                  t_in  = NIL;
                  if (head_ff == NIL) begin
                     st_in    = ST_OOM;
                     state_in = S_RESP;
                  end else begin
                     cur_in   = head_ff[IDX_W-1:0];
                     ram_re   = 1'b1;
                     ram_ra   = head_ff[IDX_W-1:0];
                     state_in = S_SCAN;
                  end
               end else if (req_item.req_addr == 16'd0) begin
                  state_in = S_RESP;
               end else if (bad_ptr) begin
                  st_in    = ST_BADPTR;
                  state_in = S_RESP;
               end else begin
                  g_in     = addr_off[IDX_W+2:3];
                  ram_re   = 1'b1;
                  ram_ra   = addr_off[IDX_W+2:3];
                  state_in = S_FG;
               end
            end
         end
         // walk the free list one header a cycle
         S_SCAN: begin
            if (take_new) begin
               t_in     = {1'b0, cur_ff};
               t_rec_in = ram_rd;
            end
            if (fit && !strat_ff) begin
               state_in = S_TAKE;
            end else if (nxt == NIL) begin
               if (take_new || t_ff != NIL) begin
                  state_in = S_TAKE;
               end else begin
                  st_in    = ST_OOM;
                  state_in = S_RESP;
               end
            end else begin
               cur_in = nxt[IDX_W-1:0];
               ram_re = 1'b1;
               ram_ra = nxt[IDX_W-1:0];
            end
         end
         // split or take whole
         S_TAKE: begin
            baddr_in = 16'({t_ff[IDX_W-1:0], 3'b000}) + 16'(HDR_SPAN);
            ret_in   = S_RESP;
            ram_we   = 1'b1;
            if (split) begin
               bsize_in = sz_ff[15:0];
               ram_wa   = nb;
               ram_wd   = '{size: t_rec_ff.size - sz_ff[15:0] - 16'(HDR_SPAN),
                            used: 1'b0, pn: t_rec_ff.pn, pp: t_ff,
                            fn: t_rec_ff.fn, fp: t_rec_ff.fp};
               pq_in[0] = '{en: t_rec_ff.pn != NIL, kind: PK_PP,
                            addr: t_rec_ff.pn[IDX_W-1:0], val: {1'b0, nb}};
               pq_in[1] = '{en: 1'b1, kind: (t_rec_ff.fp != NIL) ? PK_FN : PK_HEAD,
                            addr: t_rec_ff.fp[IDX_W-1:0], val: {1'b0, nb}};
               pq_in[2] = '{en: t_rec_ff.fn != NIL, kind: PK_FP,
                            addr: t_rec_ff.fn[IDX_W-1:0], val: {1'b0, nb}};
               state_in = S_TSPL;
            end else begin
               bsize_in = t_rec_ff.size;
               h        = t_rec_ff;
               h.used   = 1'b1;
               h.fn     = NIL;
               h.fp     = NIL;
               ram_wa   = t_ff[IDX_W-1:0];
               ram_wd   = h;
               pq_in[0] = '{en: 1'b1, kind: (t_rec_ff.fp != NIL) ? PK_FN : PK_HEAD,
                            addr: t_rec_ff.fp[IDX_W-1:0], val: t_rec_ff.fn};
               pq_in[1] = '{en: t_rec_ff.fn != NIL, kind: PK_FP,
                            addr: t_rec_ff.fn[IDX_W-1:0], val: t_rec_ff.fp};
               state_in = S_PQ;
            end
         end
         S_TSPL: begin
            h        = t_rec_ff;
            h.size   = sz_ff[15:0];
            h.used   = 1'b1;
            h.pn     = {1'b0, nb};
            h.fn     = NIL;
            h.fp     = NIL;
            ram_we   = 1'b1;
            ram_wa   = t_ff[IDX_W-1:0];
            ram_wd   = h;
            state_in = S_PQ;
         end
         // patch queue: read, modify one link, write back; a head entry sets the head register
         S_PQ: begin
            if (pe.en && pe.kind != PK_HEAD) begin
               ram_re   = 1'b1;
               ram_ra   = pe.addr;
               state_in = S_PM;
            end else begin
               if (pe.en) head_in = pe.val;
               pidx_in = pidx_ff + 2'd1;
               if (pidx_ff == 2'd3) state_in = ret_ff;
            end
         end
         S_PM: begin
            ram_we  = 1'b1;
            ram_wa  = pe.addr;
            ram_wd  = apply_patch(ram_rd, pe);
            pidx_in = pidx_ff + 2'd1;
            state_in = (pidx_ff == 2'd3) ? ret_ff : S_PQ;
         end
         // free: check header, then merge with physical successor
         S_FG: begin
            if (!ram_rd.used) begin
               st_in    = ST_DOUBLE;
               state_in = S_RESP;
            end else begin
               g_rec_in      = ram_rd;
               g_rec_in.used = 1'b0;
               if (ram_rd.pn != NIL) begin
                  ram_re   = 1'b1;
                  ram_ra   = ram_rd.pn[IDX_W-1:0];
                  state_in = S_FN;
               end else begin
                  state_in = S_FP0;
               end
            end
         end
         S_FN: begin
            state_in = S_FP0;
            if (!ram_rd.used) begin
               g_rec_in.size = g_rec_ff.size + 16'(HDR_SPAN) + ram_rd.size;
               g_rec_in.pn   = ram_rd.pn;
               pq_in[0] = '{en: 1'b1, kind: (ram_rd.fp != NIL) ? PK_FN : PK_HEAD,
                            addr: ram_rd.fp[IDX_W-1:0], val: ram_rd.fn};
               pq_in[1] = '{en: ram_rd.fn != NIL, kind: PK_FP,
                            addr: ram_rd.fn[IDX_W-1:0], val: ram_rd.fp};
               pq_in[2] = '{en: ram_rd.pn != NIL, kind: PK_PP,
                            addr: ram_rd.pn[IDX_W-1:0], val: {1'b0, g_ff}};
               pidx_in  = '0;
               ret_in   = S_FP0;
               state_in = S_PQ;
            end
         end
         // free: store merged header, look at physical predecessor
         S_FP0: begin
            for (int i = 0; i < 4; i++) pq_in[i] = '0;
            pidx_in = '0;
            ram_we  = 1'b1;
            ram_wa  = g_ff;
            ram_wd  = g_rec_ff;
            if (g_rec_ff.pp != NIL) begin
               ram_re   = 1'b1;
               ram_ra   = g_rec_ff.pp[IDX_W-1:0];
               state_in = S_FP;
            end else begin
               state_in = S_FPUSH;
            end
         end
         S_FP: begin
            if (!ram_rd.used) begin
               h        = ram_rd;
               h.size   = ram_rd.size + 16'(HDR_SPAN) + g_rec_ff.size;
               h.pn     = g_rec_ff.pn;
               ram_we   = 1'b1;
               ram_wa   = g_rec_ff.pp[IDX_W-1:0];
               ram_wd   = h;
               pq_in[0] = '{en: g_rec_ff.pn != NIL, kind: PK_PP,
                            addr: g_rec_ff.pn[IDX_W-1:0], val: g_rec_ff.pp};
               ret_in   = S_RESP;
               state_in = S_PQ;
            end else begin
               state_in = S_FPUSH;
            end
         end
         // free: push at the free-list head
         S_FPUSH: begin
            h        = g_rec_ff;
            h.fn     = head_ff;
            h.fp     = NIL;
            ram_we   = 1'b1;
            ram_wa   = g_ff;
            ram_wd   = h;
            pq_in[0] = '{en: head_ff != NIL, kind: PK_FP,
                         addr: head_ff[IDX_W-1:0], val: {1'b0, g_ff}};
            pq_in[1] = '{en: 1'b1, kind: PK_HEAD, addr: '0, val: {1'b0, g_ff}};
            pidx_in  = '0;
            ret_in   = S_RESP;
            state_in = S_PQ;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         head_ff  <= '0;
         strat_ff <= 1'b0;
         pidx_ff  <= '0;
         ret_ff   <= S_IDLE;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         strat_ff <= strat_in;
         pidx_ff  <= pidx_in;
         ret_ff   <= ret_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sz_ff    <= sz_in;
      cur_ff   <= cur_in;
      g_ff     <= g_in;
      t_ff     <= t_in;
      t_rec_ff <= t_rec_in;
      g_rec_ff <= g_rec_in;
      st_ff    <= st_in;
      baddr_ff <= baddr_in;
      bsize_ff <= bsize_in;
      for (int i = 0; i < 4; i++) pq_ff[i] <= pq_in[i];
   end

   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = state_ff == S_RESP;
   assign rsp_item  = '{status: st_ff, block_addr: baddr_ff, block_size: bsize_ff};

endmodule

### hw/rtl/hba_checker.sv
module hba_checker
   import hba_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // a result only comes while an item is in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // one strobe per item, then idle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // failed requests carry no block
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != ST_OK) |->
      (rsp_item.block_addr == 16'd0 && rsp_item.block_size == 16'd0))
      else $error("failed request reports a block");

endmodule

bind heap_block_allocator hba_checker u_hba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

### test/tb_heap_block_allocator.sv
`timescale 1ns / 1ps

module tb_heap_block_allocator;
   import hba_pkg::*;

   localparam logic FIT_FIRST = 1'b0;
   localparam logic FIT_BEST  = 1'b1;
   localparam int unsigned NO_BLOCK = GRANULES;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_data = 1'b0;

   heap_block_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // shadow heap, indexed by header granule
   int unsigned blk_size  [GRANULES];
   bit          blk_used  [GRANULES];
   int unsigned phys_next [GRANULES];
   int unsigned phys_prev [GRANULES];
   int unsigned free_next [GRANULES];
   int unsigned free_prev [GRANULES];
   int unsigned free_head;
   logic        fit_mode;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int unsigned  live_ptrs[$];
   int unsigned  freed_ptrs[$];
   int           error_count = 0;
   bit           req_taken = 1'b0;
   int           gap_left = 0;
   int           burst_left = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void heap_unlink(input int unsigned b);
      int unsigned p;
      int unsigned n;
      p = free_prev[b];
      n = free_next[b];
      if (p != NO_BLOCK) free_next[p] = n; else free_head = n;
      if (n != NO_BLOCK) free_prev[n] = p;
      free_next[b] = NO_BLOCK;
      free_prev[b] = NO_BLOCK;
   endfunction

   function automatic void heap_push(input int unsigned b);
      free_next[b] = free_head;
      free_prev[b] = NO_BLOCK;
      if (free_head != NO_BLOCK) free_prev[free_head] = b;
      free_head = b;
   endfunction

   // work out the response to one request and update the shadow heap
   function automatic rsp_item_type heap_request(input req_item_type r);
      rsp_item_type o;
      int unsigned want, c, t, nb, tn, fp, fn, g, n, p, a;
      o = '0;
      if (r.req_type == REQ_ALLOC) begin
         want = (int'(r.req_size) + 7) & 32'hFFFF_FFF8;
         c = free_head;
         t = NO_BLOCK;
         while (c != NO_BLOCK) begin
            if (blk_size[c] >= want) begin
               if (fit_mode == FIT_FIRST) begin
                  t = c;
                  break;
               end
               if (t == NO_BLOCK || blk_size[c] < blk_size[t]) t = c;
            end
            c = free_next[c];
         end
         if (t == NO_BLOCK) begin
            o.status = ST_OOM;
            return o;
         end
         nb = t + HDR_GRAN + want / GRAN_BYTES;
         if (blk_size[t] >= want + HDR_SPAN && nb < GRANULES) begin
            // split: remainder takes the free-list place of the chosen block
            tn = phys_next[t];
            fp = free_prev[t];
            fn = free_next[t];
            blk_size[nb] = blk_size[t] - want - HDR_SPAN;
            blk_used[nb] = 1'b0;
            phys_next[nb] = tn;
            phys_prev[nb] = t;
            if (tn != NO_BLOCK) phys_prev[tn] = nb;
            phys_next[t] = nb;
            free_next[nb] = fn;
            free_prev[nb] = fp;
            if (fp != NO_BLOCK) free_next[fp] = nb; else free_head = nb;
            if (fn != NO_BLOCK) free_prev[fn] = nb;
            blk_size[t] = want;
            free_next[t] = NO_BLOCK;
            free_prev[t] = NO_BLOCK;
         end else begin
            heap_unlink(t);
         end
         blk_used[t] = 1'b1;
         o.status = ST_OK;
         o.block_addr = 16'(t * GRAN_BYTES + HDR_SPAN);
         o.block_size = 16'(blk_size[t]);
         return o;
      end
      a = r.req_addr;
      o.status = ST_OK;
      if (a == 0) return o;
      if (a < HDR_SPAN || a >= GRANULES * GRAN_BYTES || ((a - HDR_SPAN) % GRAN_BYTES) != 0) begin
         o.status = ST_BADPTR;
         return o;
      end
      g = (a - HDR_SPAN) / GRAN_BYTES;
      if (!blk_used[g]) begin
         o.status = ST_DOUBLE;
         return o;
      end
      blk_used[g] = 1'b0;
      // merge with a free successor, then with a free predecessor
      n = phys_next[g];
      if (n != NO_BLOCK && !blk_used[n]) begin
         heap_unlink(n);
         blk_size[g] += HDR_SPAN + blk_size[n];
         n = phys_next[n];
         phys_next[g] = n;
         if (n != NO_BLOCK) phys_prev[n] = g;
      end
      p = phys_prev[g];
      if (p != NO_BLOCK && !blk_used[p]) begin
         blk_size[p] += HDR_SPAN + blk_size[g];
         n = phys_next[g];
         phys_next[p] = n;
         if (n != NO_BLOCK) phys_prev[n] = p;
      end else begin
         heap_push(g);
      end
      return o;
   endfunction

   // queue one request with its predicted response; track live pointers
   task automatic queue_request(input logic kind, input int unsigned size, input int unsigned addr);
      req_item_type r;
      rsp_item_type o;
      int idx;
      r.req_type = kind;
      r.req_size = 16'(size);
      r.req_addr = 16'(addr);
      o = heap_request(r);
      pending_reqs.push_back(r);
      expected_rsps.push_back(o);
      if (kind == REQ_ALLOC && o.status == ST_OK) begin
         live_ptrs.push_back(o.block_addr);
      end else if (kind == REQ_FREE && o.status == ST_OK && addr != 0) begin
         for (idx = 0; idx < live_ptrs.size(); idx++) begin
            if (live_ptrs[idx] == addr) begin
               live_ptrs.delete(idx);
               break;
            end
         end
         freed_ptrs.push_back(addr);
         if (freed_ptrs.size() > 32) void'(freed_ptrs.pop_front());
      end
   endtask

   task automatic queue_random(input int count);
      int k, pick, sel;
      int unsigned sz;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (live_ptrs.size() > 60 && pick < 55) pick += 40;
         if (pick < 55 || (pick < 90 && live_ptrs.size() == 0)) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) sz = $urandom_range(0, 512);
            else if (sel < 95) sz = $urandom_range(0, 4096);
            else sz = $urandom_range(0, 65535);
            queue_request(REQ_ALLOC, sz, $urandom_range(0, 65535));
         end else if (pick < 90) begin
            sel = $urandom_range(0, live_ptrs.size() - 1);
            queue_request(REQ_FREE, $urandom_range(0, 65535), live_ptrs[sel]);
         end else if (pick < 95 && freed_ptrs.size() > 0) begin
            sel = $urandom_range(0, freed_ptrs.size() - 1);
            queue_request(REQ_FREE, $urandom_range(0, 65535), freed_ptrs[sel]);
         end else begin
            // malformed pointer: low, misaligned, or null
            sel = $urandom_range(0, 2);
            if (sel == 0) sz = $urandom_range(0, HDR_SPAN - 1);
            else if (sel == 1) sz = ($urandom_range(0, 65535) & 16'hFFF8) | $urandom_range(1, 7);
            else sz = 0;
            queue_request(REQ_FREE, $urandom_range(0, 65535), sz);
         end
      end
   endtask

   task automatic drain_and_settle();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || start) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_strategy(input logic mode);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      fit_mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // note acceptance at the rising edge for the driver
   always @(posedge clock) begin
      req_taken = start && !busy;
   end

   // drive requests in bursts with random gaps
   always @(negedge clock) begin
      logic go;
      go = start;
      if (start && req_taken) go = 1'b0;
      if (!go && !reset && pending_reqs.size() > 0) begin
         if (gap_left > 0) begin
            gap_left--;
         end else begin
            req_item <= pending_reqs.pop_front();
            go = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
      start <= go;
   end

   // check each response against the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("responses outstanding", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch("status", rsp_item.status, want.status);
            if (rsp_item.block_addr !== want.block_addr)
               report_mismatch("block_addr", rsp_item.block_addr, want.block_addr);
            if (rsp_item.block_size !== want.block_size)
               report_mismatch("block_size", rsp_item.block_size, want.block_size);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int unsigned p;
      blk_size[0]  = HEAP_INIT;
      blk_used[0]  = 1'b0;
      phys_next[0] = NO_BLOCK;
      phys_prev[0] = NO_BLOCK;
      free_next[0] = NO_BLOCK;
      free_prev[0] = NO_BLOCK;
      free_head    = 0;
      fit_mode     = FIT_FIRST;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // directed: whole heap, out of memory, pointer checks, double free
      queue_request(REQ_ALLOC, HEAP_INIT, 16'hFFFF);
      queue_request(REQ_ALLOC, 8, 0);
      queue_request(REQ_FREE, 0, HDR_SPAN);
      queue_request(REQ_FREE, 16'hFFFF, HDR_SPAN);
      queue_request(REQ_ALLOC, 65535, 0);
      queue_request(REQ_ALLOC, 0, 0);
      queue_request(REQ_ALLOC, 1, 0);
      queue_request(REQ_ALLOC, 7, 0);
      queue_request(REQ_ALLOC, 9, 0);
      queue_request(REQ_FREE, 0, 0);
      queue_request(REQ_FREE, 0, 5);
      queue_request(REQ_FREE, 0, HDR_SPAN - 1);
      queue_request(REQ_FREE, 0, HDR_SPAN + 1);
      queue_request(REQ_FREE, 0, 16'hFFFF);
      p = live_ptrs[1];
      queue_request(REQ_FREE, 0, p);
      queue_request(REQ_FREE, 0, p);
      p = live_ptrs[1];
      queue_request(REQ_FREE, 0, p);
      queue_request(REQ_ALLOC, 40, 0);
      queue_request(REQ_ALLOC, 100, 0);
      queue_random(600);
      drain_and_settle();

      write_strategy(FIT_BEST);
      queue_random(700);
      drain_and_settle();

      write_strategy(FIT_FIRST);
      queue_random(300);
      drain_and_settle();

      write_strategy(FIT_BEST);
      queue_random(300);
      drain_and_settle();

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/hba_pkg.sv
hw/rtl/hba_ram.sv
hw/rtl/heap_block_allocator.sv
hw/rtl/hba_checker.sv
test/tb_heap_block_allocator.sv
